// ===== hdl/plc_pkg.sv =====
package plc_pkg;

  typedef enum logic [1:0] {
    StInRange  = 2'd0,
    StBadTable = 2'd1,
    StOutRange = 2'd2,
    StNoTable  = 2'd3
  } status_e;

  localparam int unsigned CfgIdxBits = 3;
  localparam logic [CfgIdxBits-1:0] RegPointCount = 3'd0;

endpackage

// ===== hdl/plc_stream_if.sv =====
interface plc_stream_if #(
  parameter int unsigned Width = 16
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/plc_cfg_if.sv =====
interface plc_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [plc_pkg::CfgIdxBits-1:0]     index;
  logic [31:0]                        wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

// ===== hdl/plc_divider.sv =====
// Pipelined signed divider, truncating toward zero, one quotient bit a stage.
module plc_divider #(
  parameter int unsigned NumBits = 34,
  parameter int unsigned DenBits = 17,
  parameter int unsigned TagBits = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic signed [NumBits-1:0] num_i,
  input  logic signed [DenBits-1:0] den_i,
  input  logic [TagBits-1:0]        tag_i,
  output logic                      valid_o,
  output logic signed [NumBits-1:0] quot_o,
  output logic [TagBits-1:0]        tag_o
);
  localparam int unsigned Stages = NumBits;

  logic [Stages:0]              vld_q;
  logic [NumBits-1:0]           rem_q [Stages+1];
  logic [NumBits-1:0]           quo_q [Stages+1];
  logic [DenBits-1:0]           den_q [Stages+1];
  logic [Stages:0]              neg_q;
  logic [TagBits-1:0]           tag_q [Stages+1];

  logic [NumBits-1:0] num_abs;
  logic [DenBits-1:0] den_abs;

  assign num_abs = num_i[NumBits-1] ? NumBits'(-num_i) : num_i;
  assign den_abs = den_i[DenBits-1] ? DenBits'(-den_i) : den_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Stages-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= '0;
      quo_q[0] <= num_abs;
      den_q[0] <= den_abs;
      neg_q[0] <= num_i[NumBits-1] ^ den_i[DenBits-1];
      tag_q[0] <= tag_i;
    end
  end

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    logic [NumBits:0] shifted;
    logic [NumBits:0] diff;
    assign shifted = {rem_q[s], quo_q[s][NumBits-1]};
    assign diff    = shifted - (NumBits+1)'(den_q[s]);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!diff[NumBits]) begin
          rem_q[s+1] <= diff[NumBits-1:0];
          quo_q[s+1] <= {quo_q[s][NumBits-2:0], 1'b1};
        end else begin
          rem_q[s+1] <= shifted[NumBits-1:0];
          quo_q[s+1] <= {quo_q[s][NumBits-2:0], 1'b0};
        end
        den_q[s+1] <= den_q[s];
        neg_q[s+1] <= neg_q[s];
        tag_q[s+1] <= tag_q[s];
      end
    end
  end

  assign valid_o = vld_q[Stages];
  assign quot_o  = neg_q[Stages] ? -$signed(quo_q[Stages]) : $signed(quo_q[Stages]);
  assign tag_o   = tag_q[Stages];
endmodule

// ===== hdl/piecewise_linear_calibration.sv =====
// Maps each converter code to a calibrated value through a table of up to
// MAX_POINTS configured points, interpolating in the first segment that holds
// the code and extrapolating otherwise (zero below two points, the code for a
// non-rising first segment), with a status per item. The datapath is a
// stall-able pipeline taking one code per cycle unless the output stalls.
// Configuration must be written only while idle; the block does not enforce it.
module piecewise_linear_calibration #(
  parameter int unsigned MAX_POINTS = 7,
  parameter int unsigned CODE_BITS  = 16,
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  plc_cfg_if.sink    cfg,
  plc_stream_if.sink in_ch,
  plc_stream_if.source out_ch
);
  localparam int unsigned IdxBits = $clog2(MAX_POINTS);
  localparam int unsigned DcBits  = CODE_BITS + 1;
  localparam int unsigned DvBits  = VALUE_BITS + 1;
  localparam int unsigned NumBits = DvBits + DcBits;
  localparam int unsigned TagBits = VALUE_BITS + 3;

  logic [2:0]                   cnt_q;
  logic [CODE_BITS-1:0]         pc_q [MAX_POINTS];
  logic signed [VALUE_BITS-1:0] pv_q [MAX_POINTS];

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      for (int k = 0; k < MAX_POINTS; k++) begin
        pc_q[k] <= '0;
        pv_q[k] <= '0;
      end
    end else if (cfg.valid) begin
      if (cfg.index == plc_pkg::RegPointCount) begin
        cnt_q <= cfg.wdata[2:0];
      end else begin
        for (int k = 0; k < MAX_POINTS; k++) begin
          if (32'(cfg.index) == 32'(k + 1)) begin
            pc_q[k] <= cfg.wdata[16 +: CODE_BITS];
            pv_q[k] <= cfg.wdata[VALUE_BITS-1:0];
          end
        end
      end
    end
  end

  // stall control: whole pipe advances together
  logic en;
  logic out_vld;
  assign en          = !out_vld || out_ch.ready;
  assign in_ch.ready = en;

  // stage 1: segment compares
  logic [CODE_BITS-1:0] x_in;
  logic [2:0]           n_eff;
  logic [IdxBits-1:0]   a_sel;
  logic [1:0]           st_sel;
  logic                 pass_sel;
  logic                 found;
  assign x_in  = in_ch.data[CODE_BITS-1:0];
  assign n_eff = (32'(cnt_q) > MAX_POINTS) ? 3'(MAX_POINTS) : cnt_q;

  always_comb begin
    found    = 1'b0;
    a_sel    = '0;
    st_sel   = plc_pkg::StOutRange;
    pass_sel = 1'b0;
    if (n_eff < 3'd2) begin
      st_sel = plc_pkg::StNoTable;
      found  = 1'b1;
    end else begin
      a_sel = IdxBits'(n_eff - 3'd2);
      for (int i = 0; i < MAX_POINTS - 1; i++) begin
        if (!found && 32'(i) < 32'(n_eff) - 1) begin
          if (pv_q[i] >= pv_q[i+1]) begin
            found  = 1'b1;
            st_sel = plc_pkg::StBadTable;
            if (i == 0) pass_sel = 1'b1;
            else a_sel = IdxBits'(i - 1);
          end else if (x_in >= pc_q[i] && x_in <= pc_q[i+1]) begin
            found  = 1'b1;
            st_sel = plc_pkg::StInRange;
            a_sel  = IdxBits'(i);
          end
        end
      end
    end
  end

  logic                         s1_v_q, s1_pass_q;
  logic [1:0]                   s1_st_q;
  logic [CODE_BITS-1:0]         s1_x_q, s1_ca_q, s1_cb_q;
  logic signed [VALUE_BITS-1:0] s1_va_q, s1_vb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_v_q <= 1'b0;
    else if (en) s1_v_q <= in_ch.valid;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_pass_q <= pass_sel;
      s1_st_q   <= st_sel;
      s1_x_q    <= x_in;
      s1_ca_q   <= pc_q[a_sel];
      s1_cb_q   <= pc_q[IdxBits'(a_sel + 1'b1)];
      s1_va_q   <= pv_q[a_sel];
      s1_vb_q   <= pv_q[IdxBits'(a_sel + 1'b1)];
    end
  end

  // stage 2: differences
  logic                     s2_v_q;
  logic signed [DvBits-1:0] s2_dv_q;
  logic signed [DcBits-1:0] s2_dx_q, s2_dc_q;
  logic [TagBits-1:0]       s2_tag_q;
  logic [CODE_BITS-1:0]     s2_x_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_v_q <= 1'b0;
    else if (en) s2_v_q <= s1_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_dv_q   <= DvBits'(s1_vb_q) - DvBits'(s1_va_q);
      s2_dx_q   <= $signed({1'b0, s1_x_q}) - $signed({1'b0, s1_ca_q});
      s2_dc_q   <= $signed({1'b0, s1_cb_q}) - $signed({1'b0, s1_ca_q});
      s2_tag_q  <= {s1_st_q, s1_pass_q, s1_va_q};
      s2_x_q    <= s1_x_q;
    end
  end

  // stage 3: product
  logic                      s3_v_q;
  logic signed [NumBits-1:0] s3_prod_q;
  logic signed [DcBits-1:0]  s3_dc_q;
  logic [TagBits-1:0]        s3_tag_q;
  logic [CODE_BITS-1:0]      s3_x_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_v_q <= 1'b0;
    else if (en) s3_v_q <= s2_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_prod_q <= NumBits'(s2_dv_q) * NumBits'(s2_dx_q);
      s3_dc_q   <= s2_dc_q;
      s3_tag_q  <= s2_tag_q;
      s3_x_q    <= s2_x_q;
    end
  end

  // x rides alongside divider via tag widening
  logic                      dv_v;
  logic signed [NumBits-1:0] quot;
  logic [TagBits+CODE_BITS:0] dtag;
  logic                      dc_zero;

  plc_divider #(
    .NumBits(NumBits),
    .DenBits(DcBits),
    .TagBits(TagBits + CODE_BITS + 1)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s3_v_q),
    .num_i   (s3_prod_q),
    .den_i   (s3_dc_q == '0 ? DcBits'(1) : s3_dc_q),
    .tag_i   ({s3_dc_q == '0, s3_x_q, s3_tag_q}),
    .valid_o (dv_v),
    .quot_o  (quot),
    .tag_o   (dtag)
  );

  assign dc_zero = dtag[TagBits+CODE_BITS];

  // final stage: add, saturate, select
  logic signed [NumBits:0]      sum;
  logic signed [31:0]           sat;
  logic signed [VALUE_BITS-1:0] va_t;
  logic [1:0]                   st_t;
  logic                         pass_t;
  logic [CODE_BITS-1:0]         x_t;
  logic signed [31:0]           res;

  assign va_t   = dtag[VALUE_BITS-1:0];
  assign pass_t = dtag[VALUE_BITS];
  assign st_t   = dtag[VALUE_BITS+2:VALUE_BITS+1];
  assign x_t    = dtag[TagBits +: CODE_BITS];
  assign sum    = (dc_zero ? '0 : (NumBits+1)'(quot)) + (NumBits+1)'(va_t);

  always_comb begin
    if (sum > (NumBits+1)'(64'sd2147483647)) sat = 32'sh7fffffff;
    else if (sum < -(NumBits+1)'(64'sd2147483648)) sat = 32'sh80000000;
    else sat = 32'(sum);
    if (st_t == plc_pkg::StNoTable) res = '0;
    else if (pass_t) res = 32'(x_t);
    else res = sat;
  end

  logic [33:0] out_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld <= 1'b0;
    else if (en) out_vld <= dv_v;
  end
  always_ff @(posedge clk_i) begin
    if (en) out_q <= {res, st_t};
  end

  assign out_ch.valid = out_vld;
  assign out_ch.data  = out_q;
endmodule

// ===== tb/tb_piecewise_linear_calibration.sv =====
module tb_piecewise_linear_calibration;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [plc_pkg::CfgIdxBits-1:0] RegPoint0 = 3'd1;
  localparam int unsigned NumPoints = 7;
  localparam int unsigned Latency = 80;
  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    logic [31:0]      calibrated;
    plc_pkg::status_e status;
  } cal_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  plc_cfg_if cfg ();
  plc_stream_if #(.Width(16)) in_ch ();
  plc_stream_if #(.Width(34)) out_ch ();

  piecewise_linear_calibration dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #2 clk_i = ~clk_i;

  logic [2:0]  tbl_count;
  logic [31:0] tbl_point [NumPoints];
  cal_item_t   cal_q [$];
  int          err_cnt = 0;
  int          cycles = 0;
  bit          no_idle = 1'b0;
  int          stall_left = 0;

  function automatic longint pt_code(int i);
    return longint'(tbl_point[i][31:16]);
  endfunction

  function automatic longint pt_val(int i);
    return longint'($signed(tbl_point[i][15:0]));
  endfunction

  function automatic longint line_at(int a, int b, longint x);
    longint dc;
    dc = pt_code(b) - pt_code(a);
    if (dc == 0) return pt_val(a);
    return ((pt_val(b) - pt_val(a)) * (x - pt_code(a))) / dc + pt_val(a);
  endfunction

  function automatic logic [31:0] sat32(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic cal_item_t calibrate(logic [15:0] code);
    cal_item_t r;
    longint x;
    int n;
    x = longint'(code);
    n = tbl_count;
    if (n < 2) begin
      r.calibrated = '0;
      r.status = plc_pkg::StNoTable;
      return r;
    end
    for (int i = 0; i < n - 1; i++) begin
      if (pt_val(i) >= pt_val(i + 1)) begin
        r.calibrated = (i == 0) ? {16'd0, code} : sat32(line_at(i - 1, i, x));
        r.status = plc_pkg::StBadTable;
        return r;
      end
      if (x >= pt_code(i) && x <= pt_code(i + 1)) begin
        r.calibrated = sat32(line_at(i, i + 1, x));
        r.status = plc_pkg::StInRange;
        return r;
      end
    end
    r.calibrated = sat32(line_at(n - 2, n - 1, x));
    r.status = plc_pkg::StOutRange;
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // output stall generator
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (no_idle) stall_left = 0;
        else stall_left = $urandom_range(0, 14);
        if (stall_left > 0) out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        if (stall_left == 0) out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cal_item_t got, want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (cal_q.size() == 0) begin
        report("unexpected item", got.calibrated, 32'd0);
      end else begin
        want = cal_q.pop_front();
        if (got.calibrated !== want.calibrated)
          report("calibrated", got.calibrated, want.calibrated);
        if (got.status !== want.status)
          report("status", 32'(got.status), 32'(want.status));
      end
    end
  end

  task automatic cfg_write(logic [plc_pkg::CfgIdxBits-1:0] idx, logic [31:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.wdata <= val;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
    cfg.valid <= 1'b0;
    if (idx == plc_pkg::RegPointCount) tbl_count = val[2:0];
    else tbl_point[idx - RegPoint0] = val;
    @(posedge clk_i);
  endtask

  task automatic load_table(int n, logic [15:0] codes [NumPoints],
                            logic [15:0] vals [NumPoints]);
    for (int i = 0; i < NumPoints; i++)
      cfg_write(plc_pkg::CfgIdxBits'(RegPoint0 + i), {codes[i], vals[i]});
    cfg_write(plc_pkg::RegPointCount, 32'(n));
  endtask

  task automatic send_code(logic [15:0] code);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= code;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    cal_q.push_back(calibrate(code));
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (cal_q.size() != 0) @(posedge clk_i);
    repeat (Latency) @(posedge clk_i);
  endtask

  task automatic test_no_table();
    send_code(16'h0000);
    send_code(16'hFFFF);
    drain();
    cfg_write(plc_pkg::RegPointCount, 32'd1);
    send_code(16'h1234);
    drain();
  endtask

  task automatic test_directed_tables();
    logic [15:0] c [NumPoints];
    logic [15:0] v [NumPoints];
    // full rising table at the extremes
    c = '{16'd0, 16'd100, 16'd1000, 16'd8000, 16'd20000, 16'd40000, 16'd65535};
    v = '{16'h8000, 16'hC000, 16'hF000, 16'h0000, 16'h1000, 16'h4000, 16'h7FFF};
    load_table(7, c, v);
    send_code(16'd0);
    send_code(16'd50);
    send_code(16'd1000);
    send_code(16'd30000);
    send_code(16'd65535);
    drain();
    // steep segment, saturates high when out of range
    c = '{16'd0, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
    v = '{16'h8000, 16'h7FFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
    load_table(2, c, v);
    send_code(16'd1);
    send_code(16'd65535);
    drain();
    // falling codes, saturates low
    c[0] = 16'd1; c[1] = 16'd0;
    load_table(2, c, v);
    send_code(16'd65535);
    send_code(16'd0);
    drain();
    // equal codes
    c[0] = 16'd500; c[1] = 16'd500;
    load_table(2, c, v);
    send_code(16'd500);
    send_code(16'd7);
    drain();
    // non-rising first segment passes the code
    c = '{16'd0, 16'd100, 16'd200, 16'd300, 16'd0, 16'd0, 16'd0};
    v = '{16'd50, 16'd50, 16'd60, 16'd70, 16'd0, 16'd0, 16'd0};
    load_table(4, c, v);
    send_code(16'd10);
    send_code(16'hABCD);
    drain();
    // non-rising later segment extrapolates along the previous one
    v = '{16'd0, 16'd100, 16'd90, 16'd200, 16'd0, 16'd0, 16'd0};
    load_table(4, c, v);
    send_code(16'd50);
    send_code(16'd150);
    send_code(16'd65535);
    drain();
  endtask

  task automatic random_table();
    logic [15:0] c [NumPoints];
    logic [15:0] v [NumPoints];
    int n, kind;
    int acc;
    kind = $urandom_range(0, 9);
    n = $urandom_range(2, 7);
    if (kind < 7) begin
      acc = $urandom_range(0, 2000);
      for (int i = 0; i < NumPoints; i++) begin
        c[i] = 16'(acc);
        acc += $urandom_range(0, 12000);
        if (acc > 65535) acc = 65535;
      end
      acc = -32768 + $urandom_range(0, 2000);
      for (int i = 0; i < NumPoints; i++) begin
        v[i] = 16'(acc);
        acc += $urandom_range(1, 9000);
        if (acc > 32767) acc = 32767;
      end
    end else begin
      for (int i = 0; i < NumPoints; i++) begin
        c[i] = 16'($urandom);
        v[i] = 16'($urandom);
      end
      if (kind == 9) n = $urandom_range(0, 7);
    end
    load_table(n, c, v);
  endtask

  task automatic test_random();
    logic [15:0] code;
    for (int t = 0; t < 11; t++) begin
      random_table();
      no_idle = (t % 4 == 3);
      for (int k = 0; k < 50; k++) begin
        if ($urandom_range(0, 3) == 0) code = 16'($urandom);
        else code = 16'(tbl_point[$urandom_range(0, 6)] >> 16)
                    + 16'($urandom_range(0, 600)) - 16'd300;
        send_code(code);
      end
      drain();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    tbl_count = '0;
    for (int i = 0; i < NumPoints; i++) tbl_point[i] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_no_table();
    test_directed_tables();
    test_random();
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
